### design/srvp_pkg.sv
// shared types and constants for the servo link response parser
// no dependencies
`default_nettype none

package srvp_pkg;

    localparam int FRAME_BYTES_DEF = 64;

    localparam logic [7:0] HDR_BYTE    = 8'h55;
    localparam logic [7:0] CMD_START   = 8'h06;
    localparam logic [7:0] CMD_STOP    = 8'h07;
    localparam logic [7:0] CMD_FINISH  = 8'h08;
    localparam logic [7:0] CMD_BATTERY = 8'h0F;

    localparam logic [7:0] LEN_GROUP   = 8'd5;
    localparam logic [7:0] LEN_STOP    = 8'd2;
    localparam logic [7:0] LEN_BATTERY = 8'd4;
    localparam logic [7:0] LEN_MIN     = 8'd2;

    // length, command and three parameter bytes are kept
    localparam int KEPT_BYTES = 5;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_ABORT = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;

    typedef logic [KEPT_BYTES-1:0][7:0] kept_t;

    typedef struct packed {
        logic [7:0] pos;
        logic [7:0] total;
    } link_t;

    typedef struct packed {
        logic [7:0]  command;
        logic [7:0]  group;
        logic [15:0] repeats;
        logic        running;
        logic        finished;
        logic [15:0] battery;
        logic [15:0] good;
        logic [15:0] bad;
    } status_t;

endpackage

`default_nettype wire

### design/srvp_step.sv
// next-state logic of the frame parser for one beat
// depends on srvp_pkg
`default_nettype none

module srvp_step
    import srvp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire logic [1:0] action,
    input  wire logic [7:0] rx_byte,
    input  wire link_t      link_cur,
    input  wire status_t    status_cur,
    input  wire kept_t      kept_cur,
    output link_t           link_next,
    output status_t         status_next,
    output kept_t           kept_next,
    output logic            done,
    output logic            error
);

    localparam logic [8:0] FRAME_LIMIT = 9'(FRAME_BYTES);

    logic [7:0] pos_inc;
    logic [7:0] slot;
    logic [8:0] total_wide;
    logic [7:0] len;
    logic [7:0] cmd;

    assign pos_inc    = link_cur.pos + 8'd1;
    assign slot       = link_cur.pos - 8'd2;
    assign total_wide = {1'b0, rx_byte} + 9'd2;

    always_comb
    begin
        link_next   = link_cur;
        status_next = status_cur;
        kept_next   = kept_cur;
        done        = 1'b0;
        error       = 1'b0;
        len         = 8'd0;
        cmd         = 8'd0;
        case (action)
            ACT_ABORT:
            begin
                link_next = '0;
            end
            ACT_RUN:
            begin
                status_next.finished = 1'b0;
            end
            ACT_BYTE:
            begin
                if (link_cur.pos == 8'd0)
                begin
                    if (rx_byte == HDR_BYTE)
                        link_next.pos = 8'd1;
                end
                else if (link_cur.pos == 8'd1)
                begin
                    link_next.pos = (rx_byte == HDR_BYTE) ? 8'd2 : 8'd0;
                end
                else if ({1'b0, link_cur.pos} >= FRAME_LIMIT)
                begin
                    // position overflow
                    link_next       = '0;
                    status_next.bad = status_cur.bad + 16'd1;
                    error           = 1'b1;
                end
                else
                begin
                    if (slot < 8'(KEPT_BYTES))
                        kept_next[slot[2:0]] = rx_byte;
                    link_next.pos = pos_inc;
                    if (pos_inc == 8'd3)
                    begin
                        // length byte
                        if (rx_byte < LEN_MIN || total_wide > FRAME_LIMIT)
                        begin
                            link_next       = '0;
                            status_next.bad = status_cur.bad + 16'd1;
                            error           = 1'b1;
                        end
                        else
                        begin
                            link_next.total = total_wide[7:0];
                        end
                    end
                    if (!error && link_next.total != 8'd0 &&
                        link_next.pos >= link_next.total)
                    begin
                        len                 = kept_next[0];
                        cmd                 = kept_next[1];
                        status_next.command = cmd;
                        status_next.good    = status_cur.good + 16'd1;
                        if ((cmd == CMD_START || cmd == CMD_FINISH) && len == LEN_GROUP)
                        begin
                            status_next.group    = kept_next[2];
                            status_next.repeats  = {kept_next[4], kept_next[3]};
                            status_next.running  = (cmd == CMD_START);
                            status_next.finished = (cmd != CMD_START);
                        end
                        else if (cmd == CMD_STOP && len == LEN_STOP)
                        begin
                            status_next.running  = 1'b0;
                            status_next.finished = 1'b0;
                        end
                        else if (cmd == CMD_BATTERY && len == LEN_BATTERY)
                        begin
                            status_next.battery = {kept_next[3], kept_next[2]};
                        end
                        link_next = '0;
                        done      = 1'b1;
                    end
                end
            end
            default:
            begin
                // unused action code: no change
            end
        endcase
    end

endmodule

`default_nettype wire

### design/servo_link_response_parser.sv
// top level of the servo link response parser: handshakes and state registers
// depends on srvp_pkg and srvp_step
`default_nettype none

// Parses the reply stream of a serial servo controller, one beat per received
// byte (or line-error / run-command event). Frames are 0x55 0x55 LEN CMD
// PARAM... with LEN+2 bytes in total; a bad length or a frame longer than
// FRAME_BYTES is dropped and counted. Every accepted beat yields exactly one
// result beat carrying the done/error flags for that beat and the status
// registers as they stand after it. A beat is taken into an input register,
// decoded by one level of next-state logic and then written to the state and
// result registers; the block sustains one beat per cycle, and the result
// register stalls the pipe only while a finished result is not taken.
module servo_link_response_parser
    import srvp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             frame_done,
    output logic             frame_error,
    output logic [7:0]       last_command,
    output logic [7:0]       group_number,
    output logic [15:0]      repeat_count,
    output logic             group_running,
    output logic             group_finished,
    output logic [15:0]      battery_millivolts,
    output logic [15:0]      good_frames,
    output logic [15:0]      bad_frames
);

    // input stage
    logic       stage_valid_reg;
    logic [1:0] stage_action_reg;
    logic [7:0] stage_byte_reg;

    // parser state; the status registers double as the result payload
    link_t      link_reg;
    status_t    status_reg;
    kept_t      kept_reg;
    logic       done_reg;
    logic       error_reg;
    logic       out_valid_reg;

    link_t      link_next;
    status_t    status_next;
    kept_t      kept_next;
    logic       done_next;
    logic       error_next;

    logic       in_accept;
    logic       advance;

    // the stage moves on whenever the result slot is empty or being emptied,
    // so the status registers only change together with a new result beat
    assign advance   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    srvp_step #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_step (
        .action      (stage_action_reg),
        .rx_byte     (stage_byte_reg),
        .link_cur    (link_reg),
        .status_cur  (status_reg),
        .kept_cur    (kept_reg),
        .link_next   (link_next),
        .status_next (status_next),
        .kept_next   (kept_next),
        .done        (done_next),
        .error       (error_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            link_reg        <= '0;
            status_reg      <= '0;
            done_reg        <= 1'b0;
            error_reg       <= 1'b0;
        end
        else
        begin
            if (in_accept)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                link_reg   <= link_next;
                status_reg <= status_next;
                done_reg   <= done_next;
                error_reg  <= error_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_action_reg <= action;
            stage_byte_reg   <= rx_byte;
        end
        if (advance)
            kept_reg <= kept_next;
    end

    assign out_valid          = out_valid_reg;
    assign frame_done         = done_reg;
    assign frame_error        = error_reg;
    assign last_command       = status_reg.command;
    assign group_number       = status_reg.group;
    assign repeat_count       = status_reg.repeats;
    assign group_running      = status_reg.running;
    assign group_finished     = status_reg.finished;
    assign battery_millivolts = status_reg.battery;
    assign good_frames        = status_reg.good;
    assign bad_frames         = status_reg.bad;

    // a beat cannot both finish and drop a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(done_reg && error_reg))
        else $error("frame done and frame error in the same beat");

    // position never runs past the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, link_reg.pos} < 9'(FRAME_BYTES))
        else $error("byte position beyond frame buffer");

    // once a length is taken, the frame is inside its body and not yet done
    assert property (@(posedge clk) disable iff (!rst_n)
        (link_reg.total != 8'd0) |-> (link_reg.pos >= 8'd3 && link_reg.pos < link_reg.total))
        else $error("expected total inconsistent with byte position");

    // a completed frame bumps the good counter by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && done_next) |=> (status_reg.good == $past(status_reg.good) + 16'd1))
        else $error("good frame counter did not advance");

    // a dropped frame bumps the bad counter by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && error_next) |=> (status_reg.bad == $past(status_reg.bad) + 16'd1))
        else $error("bad frame counter did not advance");

endmodule

`default_nettype wire
